@@ src/gloc_pkg.sv @@
// Shared types and constants for the grid line-of-sight checker.
package gloc_pkg;

    localparam int COORD_W       = 5;
    localparam int ACC_W         = COORD_W + 3;
    localparam int GRID_SIDE_DEF = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int AXES          = 3;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        t_mode                  mode;
        t_coord [AXES-1:0]      start;
        t_coord [AXES-1:0]      mag;
        logic   [AXES-1:0]      neg;
        t_coord                 len;
        logic                   occ;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } t_back_state;

endpackage

@@ src/gloc_front.sv @@
// Front end: accepts input words, works out per-axis deltas and the walk length.
module gloc_front (
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_mode,
    input  gloc_pkg::t_coord       i_start_x,
    input  gloc_pkg::t_coord       i_start_y,
    input  gloc_pkg::t_coord       i_start_z,
    input  gloc_pkg::t_coord       i_end_x,
    input  gloc_pkg::t_coord       i_end_y,
    input  gloc_pkg::t_coord       i_end_z,
    input  logic                   i_occupied_in,
    input  gloc_pkg::t_q_stat      i_q_stat,
    input  logic                   i_clearing,
    output logic                   o_push,
    output gloc_pkg::t_cmd         o_cmd
);
    import gloc_pkg::*;

    t_coord [AXES-1:0]     w_start;
    t_coord [AXES-1:0]     w_end;
    logic   [COORD_W:0]    w_diff [AXES];
    logic   [COORD_W:0]    w_abs  [AXES];
    t_coord                w_len01;

    assign w_start = {i_start_z, i_start_y, i_start_x};
    assign w_end   = {i_end_z, i_end_y, i_end_x};

    assign o_ready = !i_q_stat.full && !i_clearing;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.mode  = t_mode'(i_mode);
        o_cmd.start = w_start;
        o_cmd.occ   = i_occupied_in;
        for (int a = 0; a < AXES; a++) begin
            w_diff[a]    = {1'b0, w_end[a]} - {1'b0, w_start[a]};
            o_cmd.neg[a] = w_diff[a][COORD_W];
            w_abs[a]     = w_diff[a][COORD_W] ? -w_diff[a] : w_diff[a];
            o_cmd.mag[a] = w_abs[a][COORD_W-1:0];
        end
        // longest axis sets the number of steps
        w_len01   = (o_cmd.mag[1] > o_cmd.mag[0]) ? o_cmd.mag[1] : o_cmd.mag[0];
        o_cmd.len = (o_cmd.mag[2] > w_len01) ? o_cmd.mag[2] : w_len01;
    end

endmodule

@@ src/gloc_queue.sv @@
// Short command queue between the front end and the walk engine.
module gloc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gloc_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output gloc_pkg::t_cmd      o_cmd,
    output gloc_pkg::t_q_stat   o_stat
);
    import gloc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ src/gloc_back.sv @@
// Back end: occupancy bitmap, clearing pass, Bresenham walk and result register.
module gloc_back #(
    parameter int GRID_SIDE = gloc_pkg::GRID_SIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gloc_pkg::t_cmd      i_cmd,
    input  gloc_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_visible
);
    import gloc_pkg::*;

    localparam int CW     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int EW     = (CW > COORD_W) ? CW : COORD_W;
    localparam int MEM_AW = 3 * CW;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    t_back_state         r_state;
    t_back_state         n_state;

    logic                mem [MEM_DEPTH];
    logic                r_q;

    logic [MEM_AW-1:0]   r_clr_addr;
    logic [MEM_AW-1:0]   n_clr_addr;

    t_coord              r_pos [AXES];
    t_coord              n_pos [AXES];
    logic signed [ACC_W-1:0] r_acc [AXES];
    logic signed [ACC_W-1:0] n_acc [AXES];
    t_coord              r_mag [AXES];
    t_coord              n_mag [AXES];
    logic [AXES-1:0]     r_neg;
    logic [AXES-1:0]     n_neg;
    t_coord              r_len;
    t_coord              n_len;
    t_coord              r_cnt;
    t_coord              n_cnt;
    logic                r_all;
    logic                n_all;
    logic                r_rd_pend;
    logic                n_rd_pend;
    logic                r_rd_in;
    logic                n_rd_in;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                r_out_vis;
    logic                n_out_vis;

    logic                w_we;
    logic [MEM_AW-1:0]   w_wr_addr;
    logic                w_wr_data;
    logic [MEM_AW-1:0]   w_rd_addr;
    logic                w_out_free;

    logic signed [ACC_W-1:0] w_sum [AXES];
    logic signed [ACC_W:0]   w_twice [AXES];
    logic signed [ACC_W:0]   w_len_ext;
    logic [AXES-1:0]         w_step;

    function automatic logic [CW-1:0] axis_bits(t_coord c);
        logic [EW-1:0] e;
        e = EW'(c);
        return e[CW-1:0];
    endfunction

    function automatic logic [MEM_AW-1:0] addr_of(t_coord x, t_coord y, t_coord z);
        return {axis_bits(z), axis_bits(y), axis_bits(x)};
    endfunction

    function automatic logic in_grid(t_coord x, t_coord y, t_coord z);
        return (32'(x) < 32'(GRID_SIDE)) && (32'(y) < 32'(GRID_SIDE))
            && (32'(z) < 32'(GRID_SIDE));
    endfunction

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_visible  = r_out_vis;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_rd_addr  = addr_of(r_pos[0], r_pos[1], r_pos[2]);
    assign w_len_ext  = signed'({{(ACC_W+1-COORD_W){1'b0}}, r_len});

    // per-axis accumulator step for the point after the current one
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_sum[a]   = r_acc[a] + signed'({{(ACC_W-COORD_W){1'b0}}, r_mag[a]});
            w_twice[a] = {w_sum[a], 1'b0};
            w_step[a]  = (w_twice[a] >= w_len_ext);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_all       = r_all;
        n_rd_pend   = 1'b0;
        n_rd_in     = r_rd_in;
        n_out_valid = r_out_valid && !i_ready;
        n_out_vis   = r_out_vis;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_wr_addr   = addr_of(i_cmd.start[0], i_cmd.start[1], i_cmd.start[2]);
        w_wr_data   = i_cmd.occ;

        // fold in the bitmap bit read in the previous cycle
        if (r_rd_pend) begin
            n_all = r_all && r_rd_in && r_q;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = 1'b0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.mode == MODE_WRITE) begin
                        w_we = in_grid(i_cmd.start[0], i_cmd.start[1], i_cmd.start[2]);
                    end else begin
                        for (int a = 0; a < AXES; a++) begin
                            n_pos[a] = i_cmd.start[a];
                            n_mag[a] = i_cmd.mag[a];
                            n_acc[a] = '0;
                        end
                        n_neg   = i_cmd.neg;
                        n_len   = i_cmd.len;
                        n_cnt   = '0;
                        n_all   = 1'b1;
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                n_rd_pend = 1'b1;
                n_rd_in   = in_grid(r_pos[0], r_pos[1], r_pos[2]);
                for (int a = 0; a < AXES; a++) begin
                    if (w_step[a]) begin
                        n_acc[a] = w_sum[a] - w_len_ext[ACC_W-1:0];
                        n_pos[a] = r_neg[a] ? r_pos[a] - 1'b1 : r_pos[a] + 1'b1;
                    end else begin
                        n_acc[a] = w_sum[a];
                    end
                end
                if (r_cnt == r_len) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_vis   = r_all;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_acc     <= n_acc;
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_len     <= n_len;
        r_cnt     <= n_cnt;
        r_all     <= n_all;
        r_rd_in   <= n_rd_in;
        r_out_vis <= n_out_vis;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_q <= mem[w_rd_addr];
    end

endmodule

@@ src/grid_line_of_sight_check.sv @@
// Top level of the grid line-of-sight checker.
// Keeps one occupancy bit per point of a GRID_SIDE^3 grid. A write word (mode 0) stores
// i_occupied_in at the start point and returns nothing; a query word (mode 1)
// walks the Bresenham segment from start to end and returns o_visible = 1 only if every
// visited point is occupied. The bitmap has one read port; after a start step the walk
// reads one point per cycle, then takes in the last read and loads the result register.
// Points outside the grid read as unoccupied and writes to them are dropped. After reset
// the bitmap, 2^(3*ceil(log2(GRID_SIDE))) bits (32768 at GRID_SIDE = 32), is cleared
// one bit per cycle with o_ready low.
module grid_line_of_sight_check #(
    parameter int GRID_SIDE = gloc_pkg::GRID_SIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  gloc_pkg::t_coord    i_start_x,
    input  gloc_pkg::t_coord    i_start_y,
    input  gloc_pkg::t_coord    i_start_z,
    input  gloc_pkg::t_coord    i_end_x,
    input  gloc_pkg::t_coord    i_end_y,
    input  gloc_pkg::t_coord    i_end_z,
    input  logic                i_occupied_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_visible
);
    import gloc_pkg::*;

    t_cmd       w_push_cmd;
    t_cmd       w_head_cmd;
    t_q_stat    w_q_stat;
    logic       w_push;
    logic       w_pop;
    logic       w_clearing;

    gloc_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_start_z     (i_start_z),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_end_z       (i_end_z),
        .i_occupied_in (i_occupied_in),
        .i_q_stat      (w_q_stat),
        .i_clearing    (w_clearing),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    gloc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_q_stat)
    );

    gloc_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_head_cmd),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_visible  (o_visible)
    );

endmodule
